>>> src/bf4_pkg.sv
// Shared types, constants and helpers for the fourth-order low-pass filter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bf4_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 48;
  localparam int ACC_W    = 52;
  localparam int MUL_A_W  = 25;
  localparam int MUL_B_W  = 33;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int PACC_W   = 81;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [2:0] REG_GAIN = 3'd0;
  localparam logic [2:0] REG_F1   = 3'd1;
  localparam logic [2:0] REG_F2   = 3'd2;
  localparam logic [2:0] REG_S1   = 3'd3;
  localparam logic [2:0] REG_S2   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN_MUL,
    ST_GAIN_ACC,
    ST_HI_MUL,
    ST_LO_MUL,
    ST_LO_ACC,
    ST_SUB,
    ST_SAT,
    ST_MIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    state_t phase;
    logic   sec;
    logic   tap;
    logic   load_out;
  } ctrl_t;

  typedef struct packed {
    logic        [COEF_W-1:0] gain;
    logic signed [COEF_W-1:0] f1;
    logic signed [COEF_W-1:0] f2;
    logic signed [COEF_W-1:0] s1;
    logic signed [COEF_W-1:0] s2;
  } cfg_t;

  function automatic logic signed [HIST_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [HIST_W-1:0] r;
    if (v[ACC_W-1:HIST_W-1] == {(ACC_W-HIST_W+1){1'b0}} ||
        v[ACC_W-1:HIST_W-1] == {(ACC_W-HIST_W+1){1'b1}}) begin
      r = v[HIST_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/butterworth_lowpass_4th_order.sv
// Fourth-order low-pass filter: two cascaded biquads on one shared multiplier.
// The sequencer steps each accepted sample through nine multiplies and their
// accumulations on the one multiplier, then registers the result at sample_out.
// A new sample is taken only after the last result is loaded for output.
// Reset (rst, synchronous): config, sequencer, section history clear to zero.
// Depends on bf4_pkg, bf4_regs, bf4_seq, bf4_dp and bf4_mul.
`default_nettype none
module butterworth_lowpass_4th_order (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bf4_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [bf4_pkg::DATA_W-1:0]          pwdata,
  output logic      [bf4_pkg::DATA_W-1:0]          prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [bf4_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [bf4_pkg::SAMPLE_W-1:0] sample_out
);

  bf4_pkg::cfg_t  cfg;
  bf4_pkg::ctrl_t ctrl;

  bf4_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bf4_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  bf4_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_valid & in_ready),
    .sample_in  (sample_in),
    .cfg        (cfg),
    .ctrl       (ctrl),
    .sample_out (sample_out)
  );

endmodule
`default_nettype wire

>>> src/bf4_regs.sv
// Configuration register file behind an APB-style port.
// Depends on bf4_pkg for register codes and the cfg_t bundle.
`default_nettype none
module bf4_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bf4_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bf4_pkg::DATA_W-1:0]  pwdata,
  output logic      [bf4_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output bf4_pkg::cfg_t                    cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        bf4_pkg::REG_GAIN: cfg.gain <= pwdata;
        bf4_pkg::REG_F1:   cfg.f1   <= pwdata;
        bf4_pkg::REG_F2:   cfg.f2   <= pwdata;
        bf4_pkg::REG_S1:   cfg.s1   <= pwdata;
        bf4_pkg::REG_S2:   cfg.s2   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bf4_pkg::REG_GAIN: prdata = cfg.gain;
      bf4_pkg::REG_F1:   prdata = cfg.f1;
      bf4_pkg::REG_F2:   prdata = cfg.f2;
      bf4_pkg::REG_S1:   prdata = cfg.s1;
      bf4_pkg::REG_S2:   prdata = cfg.s2;
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/bf4_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bf4_pkg for operand widths.
`default_nettype none
module bf4_mul (
  input  wire logic                               clk,
  input  wire logic signed [bf4_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [bf4_pkg::MUL_B_W-1:0] b,
  output logic signed      [bf4_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

>>> src/bf4_seq.sv
// Sequencer that steps one sample through gain, two sections and output.
// Depends on bf4_pkg for state_t and ctrl_t.
`default_nettype none
module bf4_seq (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output bf4_pkg::ctrl_t ctrl
);

  bf4_pkg::state_t state, state_next;
  logic sec, sec_next;
  logic tap, tap_next;
  logic out_valid_next;
  logic load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bf4_pkg::ST_IDLE;
      sec       <= 1'b0;
      tap       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sec       <= sec_next;
      tap       <= tap_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    sec_next       = sec;
    tap_next       = tap;
    load_out       = 1'b0;
    out_valid_next = out_valid & ~out_ready;
    in_ready       = 1'b0;
    unique case (state)
      bf4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = bf4_pkg::ST_GAIN_MUL;
        end
      end
      bf4_pkg::ST_GAIN_MUL: state_next = bf4_pkg::ST_GAIN_ACC;
      bf4_pkg::ST_GAIN_ACC: begin
        sec_next   = 1'b0;
        tap_next   = 1'b0;
        state_next = bf4_pkg::ST_HI_MUL;
      end
      bf4_pkg::ST_HI_MUL: state_next = bf4_pkg::ST_LO_MUL;
      bf4_pkg::ST_LO_MUL: state_next = bf4_pkg::ST_LO_ACC;
      bf4_pkg::ST_LO_ACC: state_next = bf4_pkg::ST_SUB;
      bf4_pkg::ST_SUB: begin
        if (!tap) begin
          tap_next   = 1'b1;
          state_next = bf4_pkg::ST_HI_MUL;
        end else begin
          state_next = bf4_pkg::ST_SAT;
        end
      end
      bf4_pkg::ST_SAT: state_next = bf4_pkg::ST_MIX;
      bf4_pkg::ST_MIX: begin
        if (!sec) begin
          sec_next   = 1'b1;
          tap_next   = 1'b0;
          state_next = bf4_pkg::ST_HI_MUL;
        end else begin
          state_next = bf4_pkg::ST_DONE;
        end
      end
      bf4_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = bf4_pkg::ST_IDLE;
        end
      end
      default: state_next = bf4_pkg::ST_IDLE;
    endcase
  end

  assign ctrl.phase    = state;
  assign ctrl.sec      = sec;
  assign ctrl.tap      = tap;
  assign ctrl.load_out = load_out;

endmodule
`default_nettype wire

>>> src/bf4_dp.sv
// Datapath: operand selection, accumulators, saturation and section history.
// Depends on bf4_pkg and instantiates the shared multiplier bf4_mul.
`default_nettype none
module bf4_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_accept,
  input  wire logic signed [bf4_pkg::SAMPLE_W-1:0] sample_in,
  input  wire bf4_pkg::cfg_t                       cfg,
  input  wire bf4_pkg::ctrl_t                      ctrl,
  output logic signed      [bf4_pkg::SAMPLE_W-1:0] sample_out
);

  localparam int HW = bf4_pkg::HIST_W;
  localparam int AW = bf4_pkg::ACC_W;
  localparam int PW = bf4_pkg::PACC_W;

  logic signed [bf4_pkg::SAMPLE_W-1:0] x;
  logic signed [HW-1:0] fr, fo, sr, so;
  logic signed [AW-1:0] w_acc;
  logic signed [PW-1:0] pacc;
  logic signed [HW-1:0] wsat;

  logic signed [bf4_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bf4_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bf4_pkg::PROD_W-1:0]  prod;

  logic signed [HW-1:0]                 h_sel, r_sel, o_sel;
  logic signed [bf4_pkg::COEF_W-1:0]    c_sel;
  logic signed [AW-1:0]                 mix_sum;
  logic signed [HW-1:0]                 y;
  logic signed [PW-31:0]                pshift;

  bf4_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    r_sel = ctrl.sec ? sr : fr;
    o_sel = ctrl.sec ? so : fo;
    h_sel = ctrl.tap ? o_sel : r_sel;
    unique case ({ctrl.sec, ctrl.tap})
      2'b00:   c_sel = cfg.f1;
      2'b01:   c_sel = cfg.f2;
      2'b10:   c_sel = cfg.s1;
      default: c_sel = cfg.s2;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.phase)
      bf4_pkg::ST_GAIN_MUL: begin
        mul_a = {x[bf4_pkg::SAMPLE_W-1], x};
        mul_b = {1'b0, cfg.gain};
      end
      bf4_pkg::ST_HI_MUL: begin
        mul_a = {h_sel[HW-1], h_sel[HW-1:24]};
        mul_b = {c_sel[bf4_pkg::COEF_W-1], c_sel};
      end
      bf4_pkg::ST_LO_MUL: begin
        mul_a = {1'b0, h_sel[23:0]};
        mul_b = {c_sel[bf4_pkg::COEF_W-1], c_sel};
      end
      default: ;
    endcase
  end

  assign pshift  = pacc[PW-1:30];
  assign mix_sum = AW'(wsat) + (AW'(r_sel) <<< 1) + AW'(o_sel);
  assign y       = bf4_pkg::sat48(mix_sum);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x <= sample_in;
    end
    unique case (ctrl.phase)
      bf4_pkg::ST_GAIN_ACC: w_acc <= AW'(signed'(prod[55:8]));
      bf4_pkg::ST_LO_MUL:   pacc  <= PW'(prod) <<< 24;
      bf4_pkg::ST_LO_ACC:   pacc  <= pacc + PW'(prod);
      bf4_pkg::ST_SUB:      w_acc <= w_acc - AW'(pshift);
      bf4_pkg::ST_SAT:      wsat  <= bf4_pkg::sat48(w_acc);
      bf4_pkg::ST_MIX:      w_acc <= AW'(y);
      default: ;
    endcase
    if (ctrl.load_out) begin
      sample_out <= w_acc[HW-1:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr <= '0;
      fo <= '0;
      sr <= '0;
      so <= '0;
    end else if (ctrl.phase == bf4_pkg::ST_MIX) begin
      if (ctrl.sec) begin
        so <= sr;
        sr <= wsat;
      end else begin
        fo <= fr;
        fr <= wsat;
      end
    end
  end

endmodule
`default_nettype wire
